>>> sv/mal_pkg.sv
// ----------------------------------------------------------------------------
// mal_pkg: shared types and constants of the assembly line encoder
// Error codes, the line record passed from the parser to the encoder, queue
// status and numeric limits.
// ----------------------------------------------------------------------------
package mal_pkg;

    localparam int MAX_LINES_DEF      = 256;
    localparam int MNEMONIC_CHARS_DEF = 4;
    localparam int Q_DEPTH            = 2;

    localparam int NUM_W = 17;
    localparam int CLS_W = 5;

    localparam logic [NUM_W-1:0] NUM_SAT = 17'd65536;
    localparam logic [NUM_W-1:0] REG_MAX = 17'd31;
    localparam logic [NUM_W-1:0] IMM_MAX = 17'd65535;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_MNEM = 3'd1,
        ERR_SEP  = 3'd2,
        ERR_REG  = 3'd3,
        ERR_IMM  = 3'd4
    } err_t;

    // One finished line, or a reset marker when emit is low and eot is high.
    typedef struct packed {
        logic             emit;
        logic             eot;
        logic [CLS_W-1:0] cls;
        err_t             err;
        logic [NUM_W-1:0] num0;
        logic [NUM_W-1:0] num1;
        logic [NUM_W-1:0] num2;
    } line_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

>>> sv/mal_text_if.sv
// ----------------------------------------------------------------------------
// mal_text_if: character channel
// Valid/ready channel that carries one text character and its end mark.
// ----------------------------------------------------------------------------
interface mal_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

>>> sv/mal_word_if.sv
// ----------------------------------------------------------------------------
// mal_word_if: instruction word channel
// Valid/ready channel that carries one encoded line and its status.
// ----------------------------------------------------------------------------
interface mal_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic        line_valid;
    logic [2:0]  error_kind;
    logic [7:0]  line_number;
    logic        error_seen;
    logic [7:0]  first_error_line;

    modport source (output valid, output instruction_word, output line_valid,
                    output error_kind, output line_number, output error_seen,
                    output first_error_line, input ready);
    modport sink   (input valid, input instruction_word, input line_valid,
                    input error_kind, input line_number, input error_seen,
                    input first_error_line, output ready);
endinterface

>>> sv/mips_assembly_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// mips_assembly_line_encoder_unit: assembly text to MIPS word encoder
// Parses one character per cycle unless stalled; one 32-bit word per line.
// ----------------------------------------------------------------------------
// Usage:
// The text channel takes one character per transfer, with end_of_text set
// on the final character. The words channel gives one transfer per finished
// line: the encoded word, a line status with error kind, the line index and
// a sticky record of the first failing line. Empty lines give nothing.
// The block accepts one character every cycle while the record queue is
// not full. The parser keeps its state in registers and updates it with
// each accepted character; its only dependency loop is that per-character update.
// A line's record is written into the two-entry queue at the transfer of
// the character that ends it. The encoder takes the record from the queue
// once the output stage is free or being read, and registers the word,
// which is then valid on the words channel.
// When the receiver stalls, the output stage holds its word and the queue
// fills; text.ready drops only once both queue entries are taken.
// Reset clears parser, queue, line count and sticky record; the same clear
// of count and record follows the line carrying end_of_text.
// ----------------------------------------------------------------------------
module mips_assembly_line_encoder_unit #(
    parameter int MAX_LINES      = mal_pkg::MAX_LINES_DEF,
    parameter int MNEMONIC_CHARS = mal_pkg::MNEMONIC_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mal_text_if.sink   text,
    mal_word_if.source words
);

    mal_pkg::line_rec_t   push_rec;
    mal_pkg::line_rec_t   head_rec;
    mal_pkg::queue_stat_t qstat;
    logic                 push;
    logic                 pop;

    mal_front #(
        .MNEMONIC_CHARS(MNEMONIC_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .qstat    (qstat),
        .rec_push (push),
        .rec      (push_rec)
    );

    mal_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .qstat    (qstat)
    );

    mal_back #(
        .MAX_LINES(MAX_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (!qstat.empty),
        .rec       (head_rec),
        .rec_take  (pop),
        .words     (words)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty at once");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("line record pushed into a full queue");

    a_failed_line: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && !words.line_valid |->
            words.instruction_word == 32'd0 && words.error_seen
            && words.error_kind != mal_pkg::ERR_NONE)
        else $error("failed line without zero word or sticky record");

    a_first_error_order: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && words.error_seen |-> words.first_error_line <= words.line_number)
        else $error("first failing line lies after the current line");

endmodule

>>> sv/mal_front.sv
// ----------------------------------------------------------------------------
// mal_front: character parser
// Walks each line through mnemonic, separators and operands, one character
// per cycle while the queue has room, and queues a line record at line end.
// ----------------------------------------------------------------------------
module mal_front #(
    parameter int MNEMONIC_CHARS = mal_pkg::MNEMONIC_CHARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    mal_text_if.sink            text,
    input  mal_pkg::queue_stat_t qstat,
    output logic                rec_push,
    output mal_pkg::line_rec_t  rec
);

    localparam int LEN_W = $clog2(MNEMONIC_CHARS + 2);
    localparam int IDX_W = $clog2(MNEMONIC_CHARS);
    localparam int NW    = mal_pkg::NUM_W;
    localparam int CW    = mal_pkg::CLS_W;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Classes 1 through CLASS_LAST_R are the register-register group.
    localparam logic [CW-1:0] CLASS_LAST_R = 5'd7;
    localparam logic [CW-1:0] CLASS_BGTZ   = 5'd16;

    localparam logic [31:0] MN_NAME [16] = '{
        {"add", 8'h00}, {"sub", 8'h00}, {"mul", 8'h00}, {"div", 8'h00},
        {"or", 16'h0000}, {"and", 8'h00}, {"slt", 8'h00}, "addi",
        {"ori", 8'h00}, "andi", {"lw", 16'h0000}, {"sw", 16'h0000},
        "slti", {"beq", 8'h00}, {"bne", 8'h00}, "bgtz"
    };
    localparam logic [2:0] MN_LEN [16] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd3, 3'd3, 3'd4
    };

    typedef enum logic [8:0] {
        PH_MNEM = 9'b000000001,
        PH_S1   = 9'b000000010,
        PH_N1   = 9'b000000100,
        PH_S2A  = 9'b000001000,
        PH_S2B  = 9'b000010000,
        PH_N2   = 9'b000100000,
        PH_S3A  = 9'b001000000,
        PH_S3B  = 9'b010000000,
        PH_N3   = 9'b100000000
    } phase_t;

    // Returns the mnemonic class (1..16) or zero when nothing matches.
    // A length code of 7 stands for any length above four.
    function automatic logic [CW-1:0] lookup(input logic [3:0][7:0] chars,
                                             input logic [2:0] len);
        logic [CW-1:0] cls;
        logic          hit;
        logic          all_up;
        logic          rest_low;
        logic          up;
        logic [7:0]    ch;
        logic [7:0]    lc;
        cls = '0;
        for (int i = 15; i >= 0; i--) begin
            hit      = (len == MN_LEN[i]);
            all_up   = 1'b1;
            rest_low = 1'b1;
            for (int p = 0; p < 4; p++) begin
                ch = chars[p];
                up = (ch >= "A") && (ch <= "Z");
                lc = up ? 8'(ch + 8'd32) : ch;
                if (3'(p) < MN_LEN[i]) begin
                    if (lc != MN_NAME[i][31-8*p -: 8]) hit = 1'b0;
                    if (!up) all_up = 1'b0;
                    if (p > 0 && !((ch >= "a") && (ch <= "z"))) rest_low = 1'b0;
                end
            end
            if (hit && (all_up || rest_low)) cls = CW'(i + 1);
        end
        return cls;
    endfunction

    function automatic logic [NW-1:0] acc(input logic [NW-1:0] v, input logic [7:0] ch);
        logic [20:0] w;
        w = (21'(v) << 3) + (21'(v) << 1) + 21'(8'(ch - CH_ZERO));
        return (w > 21'(mal_pkg::NUM_SAT)) ? mal_pkg::NUM_SAT : w[NW-1:0];
    endfunction

    phase_t          phase_reg, phase_next;
    logic [7:0]      mnem_reg [MNEMONIC_CHARS];
    logic [7:0]      mnem_next [MNEMONIC_CHARS];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [NW-1:0]   num0_reg, num0_next;
    logic [NW-1:0]   num1_reg, num1_next;
    logic [NW-1:0]   num2_reg, num2_next;
    logic            stop_reg, stop_next;
    logic            start_reg, start_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cls_reg, cls_next;
    mal_pkg::err_t   err_reg, err_next;

    logic [7:0]      c;
    logic            nl;
    logic            accept;
    logic            empty_line;
    logic            line_end;
    logic            reset_only;
    logic [NW-1:0]   cur_num;
    logic [NW-1:0]   fed_num;
    logic            is_digit;
    logic [3:0][7:0] head_chars;
    logic [2:0]      len_code;
    logic [CW-1:0]   found_cls;

    assign c        = text.char_in;
    assign nl       = (c == CH_NL);
    assign accept   = text.valid && text.ready;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign fed_num  = acc(cur_num, c);

    assign text.ready = !qstat.full;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            head_chars[p] = mnem_reg[p];
        end
        len_code  = (len_reg <= LEN_W'(4)) ? len_reg[2:0] : 3'd7;
        found_cls = lookup(head_chars, len_code);
    end

    always_comb
    begin
        case (phase_reg)
            PH_N1:   cur_num = num0_reg;
            PH_N2:   cur_num = num1_reg;
            default: cur_num = num2_reg;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        mnem_next  = mnem_reg;
        len_next   = len_reg;
        num0_next  = num0_reg;
        num1_next  = num1_reg;
        num2_next  = num2_reg;
        stop_next  = stop_reg;
        start_next = start_reg;
        neg_next   = neg_reg;
        cls_next   = cls_reg;
        err_next   = err_reg;

        if (!nl)
        begin
            case (phase_reg)
                PH_MNEM:
                begin
                    if (c == CH_SPACE)
                    begin
                        cls_next = found_cls;
                        if (found_cls == '0 && err_reg == mal_pkg::ERR_NONE)
                        begin
                            err_next = mal_pkg::ERR_MNEM;
                        end
                        phase_next = PH_S1;
                    end
                    else
                    begin
                        if (len_reg < LEN_W'(MNEMONIC_CHARS))
                        begin
                            mnem_next[len_reg[IDX_W-1:0]] = c;
                        end
                        if (len_reg <= LEN_W'(MNEMONIC_CHARS))
                        begin
                            len_next = len_reg + LEN_W'(1);
                        end
                    end
                end
                PH_S1, PH_S2B, PH_S3B:
                begin
                    if (phase_reg == PH_S3B)
                    begin
                        // R-type wants a register, I-type an immediate; an
                        // unknown mnemonic takes either marker.
                        if (cls_reg == '0)
                        begin
                            if (c != CH_DOLLAR && c != CH_HASH && err_reg == mal_pkg::ERR_NONE)
                            begin
                                err_next = mal_pkg::ERR_SEP;
                            end
                        end
                        else if (cls_reg <= CLASS_LAST_R)
                        begin
                            if (c != CH_DOLLAR && err_reg == mal_pkg::ERR_NONE)
                            begin
                                err_next = mal_pkg::ERR_SEP;
                            end
                        end
                        else if (c != CH_HASH && err_reg == mal_pkg::ERR_NONE)
                        begin
                            err_next = mal_pkg::ERR_SEP;
                        end
                    end
                    else if (c != CH_DOLLAR && err_reg == mal_pkg::ERR_NONE)
                    begin
                        err_next = mal_pkg::ERR_SEP;
                    end
                    stop_next  = 1'b0;
                    start_next = 1'b0;
                    neg_next   = 1'b0;
                    case (phase_reg)
                        PH_S1:   phase_next = PH_N1;
                        PH_S2B:  phase_next = PH_N2;
                        default: phase_next = PH_N3;
                    endcase
                end
                PH_S2A, PH_S3A:
                begin
                    if (c != CH_SPACE && err_reg == mal_pkg::ERR_NONE)
                    begin
                        err_next = mal_pkg::ERR_SEP;
                    end
                    phase_next = (phase_reg == PH_S2A) ? PH_S2B : PH_S3B;
                end
                PH_N1, PH_N2, PH_N3:
                begin
                    if (c == CH_COMMA && phase_reg != PH_N3)
                    begin
                        if (phase_reg == PH_N1)
                        begin
                            if (neg_reg && num0_reg != '0) num0_next = mal_pkg::NUM_SAT;
                            phase_next = (cls_reg == CLASS_BGTZ) ? PH_S3A : PH_S2A;
                        end
                        else
                        begin
                            if (neg_reg && num1_reg != '0) num1_next = mal_pkg::NUM_SAT;
                            phase_next = PH_S3A;
                        end
                        stop_next  = 1'b0;
                        start_next = 1'b0;
                        neg_next   = 1'b0;
                    end
                    else if (!stop_reg)
                    begin
                        if (is_digit)
                        begin
                            case (phase_reg)
                                PH_N1:   num0_next = fed_num;
                                PH_N2:   num1_next = fed_num;
                                default: num2_next = fed_num;
                            endcase
                            start_next = 1'b1;
                        end
                        else if (c == CH_MINUS && !start_reg)
                        begin
                            neg_next   = 1'b1;
                            start_next = 1'b1;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_MNEM;
                end
            endcase
        end
    end

    // A newline with nothing received is no line at all.
    assign empty_line = (phase_reg == PH_MNEM) && (len_reg == '0);
    assign line_end   = nl ? !empty_line : text.end_of_text;
    assign reset_only = nl && empty_line && text.end_of_text;
    assign rec_push   = accept && (line_end || reset_only);

    always_comb
    begin
        rec.emit = line_end;
        rec.eot  = text.end_of_text;
        rec.cls  = cls_next;
        rec.num0 = num0_next;
        rec.num1 = num1_next;
        if (phase_next != PH_N3 && err_next == mal_pkg::ERR_NONE)
        begin
            rec.err = mal_pkg::ERR_SEP;
        end
        else
        begin
            rec.err = err_next;
        end
        if (phase_next == PH_N3 && neg_next && num2_next != '0)
        begin
            rec.num2 = mal_pkg::NUM_SAT;
        end
        else
        begin
            rec.num2 = num2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MNEM;
            len_reg   <= '0;
            num0_reg  <= '0;
            num1_reg  <= '0;
            num2_reg  <= '0;
            stop_reg  <= 1'b0;
            start_reg <= 1'b0;
            neg_reg   <= 1'b0;
            cls_reg   <= '0;
            err_reg   <= mal_pkg::ERR_NONE;
            for (int i = 0; i < MNEMONIC_CHARS; i++)
            begin
                mnem_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (line_end || reset_only)
            begin
                phase_reg <= PH_MNEM;
                len_reg   <= '0;
                num0_reg  <= '0;
                num1_reg  <= '0;
                num2_reg  <= '0;
                stop_reg  <= 1'b0;
                start_reg <= 1'b0;
                neg_reg   <= 1'b0;
                cls_reg   <= '0;
                err_reg   <= mal_pkg::ERR_NONE;
                for (int i = 0; i < MNEMONIC_CHARS; i++)
                begin
                    mnem_reg[i] <= '0;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                num0_reg  <= num0_next;
                num1_reg  <= num1_next;
                num2_reg  <= num2_next;
                stop_reg  <= stop_next;
                start_reg <= start_next;
                neg_reg   <= neg_next;
                cls_reg   <= cls_next;
                err_reg   <= err_next;
                mnem_reg  <= mnem_next;
            end
        end
    end

endmodule

>>> sv/mal_queue.sv
// ----------------------------------------------------------------------------
// mal_queue: line record queue
// Short first-in first-out buffer that decouples the parser from the encoder.
// ----------------------------------------------------------------------------
module mal_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mal_pkg::line_rec_t   push_rec,
    input  logic                 pop,
    output mal_pkg::line_rec_t   head_rec,
    output mal_pkg::queue_stat_t qstat
);

    localparam int DEPTH = mal_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mal_pkg::line_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head_rec    = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/mal_back.sv
// ----------------------------------------------------------------------------
// mal_back: range check and word packing
// Takes line records from the queue, checks operand ranges, packs the word,
// keeps the line count and sticky error record, and drives the output stage.
// ----------------------------------------------------------------------------
module mal_back #(
    parameter int MAX_LINES = mal_pkg::MAX_LINES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    input  mal_pkg::line_rec_t rec,
    output logic               rec_take,
    mal_word_if.source         words
);

    localparam int LAST_LINE = (MAX_LINES < 256) ? MAX_LINES - 1 : 255;
    localparam int LINE_W    = $clog2(LAST_LINE + 1);

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_R    = 2'd1,
        KIND_IA   = 2'd2,
        KIND_LB   = 2'd3
    } kind_t;

    localparam kind_t MN_KIND [16] = '{
        KIND_R, KIND_R, KIND_R, KIND_R, KIND_R, KIND_R, KIND_R,
        KIND_IA, KIND_IA, KIND_IA, KIND_LB, KIND_LB, KIND_IA, KIND_LB, KIND_LB, KIND_LB
    };
    // Function field for R-type, opcode for the rest.
    localparam logic [5:0] MN_CODE [16] = '{
        6'b100000, 6'b100010, 6'b011000, 6'b011010, 6'b100101, 6'b100100, 6'b101010,
        6'b001000, 6'b001101, 6'b001100, 6'b100011, 6'b101011, 6'b001010,
        6'b000100, 6'b000101, 6'b000111
    };

    logic [LINE_W-1:0] line_reg, line_next;
    logic              sticky_reg, sticky_next;
    logic [LINE_W-1:0] eline_reg, eline_next;
    logic              out_valid_reg, out_valid_next;

    logic [31:0]       word_reg;
    logic              ok_reg;
    logic [2:0]        kind_out_reg;
    logic [7:0]        num_out_reg;
    logic              seen_out_reg;
    logic [7:0]        first_out_reg;

    logic [3:0]        tab_idx;
    kind_t             kind;
    logic [5:0]        code;
    logic              reg_bad;
    logic              imm_bad;
    mal_pkg::err_t     err_fin;
    logic [31:0]       word;
    logic [4:0]        fa;
    logic [4:0]        fb;
    logic [15:0]       ft;

    assign rec_take = rec_valid && (!out_valid_reg || words.ready);

    assign tab_idx = 4'(rec.cls - mal_pkg::CLS_W'(1));
    assign kind    = (rec.cls == '0) ? KIND_NONE : MN_KIND[tab_idx];
    assign code    = MN_CODE[tab_idx];
    assign fa      = rec.num0[4:0];
    assign fb      = rec.num1[4:0];
    assign ft      = rec.num2[15:0];

    always_comb
    begin
        reg_bad = (rec.num0 > mal_pkg::REG_MAX) || (rec.num1 > mal_pkg::REG_MAX)
               || (kind == KIND_R && rec.num2 > mal_pkg::REG_MAX);
        imm_bad = (rec.num2 > mal_pkg::IMM_MAX);

        // Parse errors win over range errors, registers over the immediate.
        err_fin = rec.err;
        if (rec.err == mal_pkg::ERR_NONE)
        begin
            if (reg_bad)
            begin
                err_fin = mal_pkg::ERR_REG;
            end
            else if (imm_bad)
            begin
                err_fin = mal_pkg::ERR_IMM;
            end
        end

        word = '0;
        if (err_fin == mal_pkg::ERR_NONE)
        begin
            case (kind)
                KIND_R:  word = {6'b000000, fb, ft[4:0], fa, 5'b00000, code};
                KIND_IA: word = {code, fb, fa, ft};
                KIND_LB: word = {code, fa, fb, ft};
                default: word = '0;
            endcase
        end

        sticky_next = sticky_reg;
        eline_next  = eline_reg;
        if (err_fin != mal_pkg::ERR_NONE && !sticky_reg)
        begin
            sticky_next = 1'b1;
            eline_next  = line_reg;
        end

        line_next = line_reg;
        if (line_reg < LINE_W'(LAST_LINE))
        begin
            line_next = line_reg + LINE_W'(1);
        end

        out_valid_next = out_valid_reg && !words.ready;
        if (rec_take && rec.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take && rec.emit)
        begin
            word_reg      <= word;
            ok_reg        <= (err_fin == mal_pkg::ERR_NONE);
            kind_out_reg  <= err_fin;
            num_out_reg   <= 8'(line_reg);
            seen_out_reg  <= sticky_next;
            first_out_reg <= sticky_next ? 8'(eline_next) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            sticky_reg    <= 1'b0;
            eline_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (rec_take)
            begin
                // End of text returns the record to its reset state.
                if (rec.eot)
                begin
                    line_reg   <= '0;
                    sticky_reg <= 1'b0;
                    eline_reg  <= '0;
                end
                else if (rec.emit)
                begin
                    line_reg   <= line_next;
                    sticky_reg <= sticky_next;
                    eline_reg  <= eline_next;
                end
            end
        end
    end

    assign words.valid            = out_valid_reg;
    assign words.instruction_word = word_reg;
    assign words.line_valid       = ok_reg;
    assign words.error_kind       = kind_out_reg;
    assign words.line_number      = num_out_reg;
    assign words.error_seen       = seen_out_reg;
    assign words.first_error_line = first_out_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: line-by-line check of the MIPS assembly line encoder
// Streams assembly text into the block one character per transfer. A
// tracker class follows the parser character by character, works out the
// word and status each finished line must give, and compares every word
// transfer against the oldest line it holds. Both channels idle at random,
// and the word side holds off once for a long stretch so the text side
// backs up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TEXT_TARGET  = 1750;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 10;
    localparam int LAST_LINE    = (mal_pkg::MAX_LINES_DEF < 256) ?
                                  mal_pkg::MAX_LINES_DEF - 1 : 255;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Function codes of the R-type group and opcodes of the rest.
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_MUL  = 6'd24;
    localparam logic [5:0] FN_DIV  = 6'd26;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_SLT  = 6'd42;
    localparam logic [5:0] OP_ADDI = 6'd8;
    localparam logic [5:0] OP_ORI  = 6'd13;
    localparam logic [5:0] OP_ANDI = 6'd12;
    localparam logic [5:0] OP_LW   = 6'd35;
    localparam logic [5:0] OP_SW   = 6'd43;
    localparam logic [5:0] OP_SLTI = 6'd10;
    localparam logic [5:0] OP_BEQ  = 6'd4;
    localparam logic [5:0] OP_BNE  = 6'd5;
    localparam logic [5:0] OP_BGTZ = 6'd7;

    typedef enum logic [3:0] {
        PH_MNEMONIC, PH_DOLLAR1, PH_REG1, PH_SPACE2, PH_DOLLAR2, PH_REG2,
        PH_SPACE3, PH_MARK3, PH_OPERAND3
    } phase_t;

    typedef enum logic [1:0] {FMT_NONE, FMT_R, FMT_IA, FMT_LB} fmt_t;

    typedef enum int {
        MN_ADD, MN_SUB, MN_MUL, MN_DIV, MN_OR, MN_AND, MN_SLT, MN_ADDI,
        MN_ORI, MN_ANDI, MN_LW, MN_SW, MN_SLTI, MN_BEQ, MN_BNE, MN_BGTZ
    } mnem_t;

    typedef struct packed {
        logic [31:0] word;
        logic        ok;
        logic [2:0]  kind;
        logic [7:0]  line;
        logic        seen;
        logic [7:0]  first_line;
    } word_res_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    class asm_line_tracker;
        phase_t        phase;
        logic [7:0]    mnem [4];
        int unsigned   mnem_len;
        int unsigned   operand [3];
        bit            halted;
        bit            started;
        bit            minus;
        bit            known;
        mnem_t         mnem_id;
        mal_pkg::err_t line_err;
        int unsigned   line_cnt;
        bit            sticky;
        int unsigned   sticky_line;
        word_res_t     pending_words[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
            reset_all();
        endfunction

        function string spelled(mnem_t id);
            case (id)
                MN_ADD:  return "add";
                MN_SUB:  return "sub";
                MN_MUL:  return "mul";
                MN_DIV:  return "div";
                MN_OR:   return "or";
                MN_AND:  return "and";
                MN_SLT:  return "slt";
                MN_ADDI: return "addi";
                MN_ORI:  return "ori";
                MN_ANDI: return "andi";
                MN_LW:   return "lw";
                MN_SW:   return "sw";
                MN_SLTI: return "slti";
                MN_BEQ:  return "beq";
                MN_BNE:  return "bne";
                default: return "bgtz";
            endcase
        endfunction

        function fmt_t form_of(mnem_t id);
            case (id)
                MN_ADD, MN_SUB, MN_MUL, MN_DIV, MN_OR, MN_AND, MN_SLT: return FMT_R;
                MN_ADDI, MN_ORI, MN_ANDI, MN_SLTI:                   return FMT_IA;
                default:                                             return FMT_LB;
            endcase
        endfunction

        function logic [5:0] code_of(mnem_t id);
            case (id)
                MN_ADD:  return FN_ADD;
                MN_SUB:  return FN_SUB;
                MN_MUL:  return FN_MUL;
                MN_DIV:  return FN_DIV;
                MN_OR:   return FN_OR;
                MN_AND:  return FN_AND;
                MN_SLT:  return FN_SLT;
                MN_ADDI: return OP_ADDI;
                MN_ORI:  return OP_ORI;
                MN_ANDI: return OP_ANDI;
                MN_LW:   return OP_LW;
                MN_SW:   return OP_SW;
                MN_SLTI: return OP_SLTI;
                MN_BEQ:  return OP_BEQ;
                MN_BNE:  return OP_BNE;
                default: return OP_BGTZ;
            endcase
        endfunction

        function fmt_t line_form();
            return known ? form_of(mnem_id) : FMT_NONE;
        endfunction

        function void start_operand();
            halted  = 0;
            started = 0;
            minus   = 0;
        endfunction

        function void clear_line();
            int i;
            phase = PH_MNEMONIC;
            for (i = 0; i < 4; i++)
                mnem[i] = 8'h00;
            mnem_len = 0;
            for (i = 0; i < 3; i++)
                operand[i] = 0;
            start_operand();
            known    = 0;
            mnem_id  = MN_ADD;
            line_err = mal_pkg::ERR_NONE;
        endfunction

        function void reset_all();
            clear_line();
            line_cnt    = 0;
            sticky      = 0;
            sticky_line = 0;
        endfunction

        function bit is_up(logic [7:0] c);
            return c >= "A" && c <= "Z";
        endfunction

        function bit is_low(logic [7:0] c);
            return c >= "a" && c <= "z";
        endfunction

        // Accepted spellings are all lower, capitalized, or all upper.
        function bit name_hit(mnem_t id);
            string      nm;
            int         i;
            bit         rest_lower;
            bit         all_upper;
            logic [7:0] c;
            logic [7:0] lc;
            nm = spelled(id);
            rest_lower = 1;
            all_upper  = 1;
            if (mnem_len != nm.len())
                return 0;
            for (i = 0; i < nm.len(); i++)
            begin
                c  = mnem[i];
                lc = is_up(c) ? c + 8'd32 : c;
                if (lc != nm.getc(i))
                    return 0;
                if (!is_up(c))
                    all_upper = 0;
                if (i > 0 && !is_low(c))
                    rest_lower = 0;
            end
            return rest_lower || all_upper;
        endfunction

        function void decode();
            int i;
            known = 0;
            if (mnem_len <= mal_pkg::MNEMONIC_CHARS_DEF)
            begin
                for (i = 0; i < 16; i++)
                begin
                    if (!known && name_hit(mnem_t'(i)))
                    begin
                        known   = 1;
                        mnem_id = mnem_t'(i);
                    end
                end
            end
            if (!known && line_err == mal_pkg::ERR_NONE)
                line_err = mal_pkg::ERR_MNEM;
        endfunction

        function void sep_fault();
            if (line_err == mal_pkg::ERR_NONE)
                line_err = mal_pkg::ERR_SEP;
        endfunction

        // Digits accumulate with saturation until the first non-digit past a leading minus.
        function void feed(int k, logic [7:0] c);
            int unsigned v;
            if (halted)
                return;
            if (c >= "0" && c <= "9")
            begin
                v = operand[k] * 10 + (c - "0");
                operand[k] = (v > mal_pkg::NUM_SAT) ? mal_pkg::NUM_SAT : v;
                started = 1;
            end
            else if (c == "-" && !started)
            begin
                minus   = 1;
                started = 1;
            end
            else
                halted = 1;
        endfunction

        function void close_operand(int k);
            if (minus && operand[k] != 0)
                operand[k] = mal_pkg::NUM_SAT;
            start_operand();
        endfunction

        function void finish_line();
            fmt_t       fmt;
            word_res_t  res;
            logic [5:0] code;
            logic [4:0] ra;
            logic [4:0] rb;
            logic [15:0] imm;
            fmt = line_form();
            if (phase != PH_OPERAND3)
                sep_fault();
            else
                close_operand(2);
            if (line_err == mal_pkg::ERR_NONE)
            begin
                if (operand[0] > mal_pkg::REG_MAX || operand[1] > mal_pkg::REG_MAX ||
                    (fmt == FMT_R && operand[2] > mal_pkg::REG_MAX))
                    line_err = mal_pkg::ERR_REG;
                else if (operand[2] > mal_pkg::IMM_MAX)
                    line_err = mal_pkg::ERR_IMM;
            end
            res.word = 32'd0;
            if (line_err == mal_pkg::ERR_NONE)
            begin
                code = code_of(mnem_id);
                ra   = 5'(operand[0]);
                rb   = 5'(operand[1]);
                imm  = 16'(operand[2]);
                if (fmt == FMT_R)
                    res.word = {6'd0, rb, imm[4:0], ra, 5'd0, code};
                else if (fmt == FMT_IA)
                    res.word = {code, rb, ra, imm};
                else
                    res.word = {code, ra, rb, imm};
            end
            else if (!sticky)
            begin
                sticky      = 1;
                sticky_line = line_cnt;
            end
            res.ok         = (line_err == mal_pkg::ERR_NONE);
            res.kind       = line_err;
            res.line       = 8'(line_cnt);
            res.seen       = sticky;
            res.first_line = sticky ? 8'(sticky_line) : 8'd0;
            pending_words.push_back(res);
            if (line_cnt < LAST_LINE)
                line_cnt++;
            clear_line();
        endfunction

        // Follows one accepted character through the parser.
        function void take_char(logic [7:0] c, logic eot);
            fmt_t fmt;
            if (c == CH_LF)
            begin
                if (!(phase == PH_MNEMONIC && mnem_len == 0))
                    finish_line();
                if (eot)
                    reset_all();
                return;
            end
            case (phase)
                PH_MNEMONIC:
                begin
                    if (c == " ")
                    begin
                        decode();
                        phase = PH_DOLLAR1;
                    end
                    else
                    begin
                        if (mnem_len < mal_pkg::MNEMONIC_CHARS_DEF)
                            mnem[mnem_len] = c;
                        if (mnem_len <= mal_pkg::MNEMONIC_CHARS_DEF)
                            mnem_len++;
                    end
                end
                PH_DOLLAR1:
                begin
                    if (c != "$")
                        sep_fault();
                    start_operand();
                    phase = PH_REG1;
                end
                PH_REG1:
                begin
                    if (c == ",")
                    begin
                        close_operand(0);
                        // bgtz has no second register.
                        phase = (known && mnem_id == MN_BGTZ) ? PH_SPACE3 : PH_SPACE2;
                    end
                    else
                        feed(0, c);
                end
                PH_SPACE2:
                begin
                    if (c != " ")
                        sep_fault();
                    phase = PH_DOLLAR2;
                end
                PH_DOLLAR2:
                begin
                    if (c != "$")
                        sep_fault();
                    start_operand();
                    phase = PH_REG2;
                end
                PH_REG2:
                begin
                    if (c == ",")
                    begin
                        close_operand(1);
                        phase = PH_SPACE3;
                    end
                    else
                        feed(1, c);
                end
                PH_SPACE3:
                begin
                    if (c != " ")
                        sep_fault();
                    phase = PH_MARK3;
                end
                PH_MARK3:
                begin
                    fmt = line_form();
                    if (fmt == FMT_R)
                    begin
                        if (c != "$")
                            sep_fault();
                    end
                    else if (fmt != FMT_NONE)
                    begin
                        if (c != "#")
                            sep_fault();
                    end
                    else if (c != "$" && c != "#")
                        sep_fault();
                    start_operand();
                    phase = PH_OPERAND3;
                end
                PH_OPERAND3:
                    feed(2, c);
                default:
                    clear_line();
            endcase
            if (eot)
            begin
                finish_line();
                reset_all();
            end
        endfunction

        function void compare_word(word_res_t got);
            word_res_t exp;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h for line %0d at %0t",
                             got.word, got.line, $realtime);
                return;
            end
            exp = pending_words.pop_front();
            if (got.word !== exp.word || got.ok !== exp.ok || got.kind !== exp.kind ||
                got.line !== exp.line || got.seen !== exp.seen ||
                got.first_line !== exp.first_line)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: expected word %h ok %0d kind %0d line %0d",
                             $realtime, exp.word, exp.ok, exp.kind, exp.line);
                    $display("    seen %0d first %0d; got word %h ok %0d kind %0d line %0d",
                             exp.seen, exp.first_line, got.word, got.ok, got.kind, got.line);
                    $display("    seen %0d first %0d", got.seen, got.first_line);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mal_text_if text_bus ();
    mal_word_if word_bus ();

    mips_assembly_line_encoder_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_bus),
        .words (word_bus)
    );

    asm_line_tracker board = new();

    text_item_t  stim_q[$];
    logic [7:0]  lbuf[$];
    int unsigned words_seen  = 0;
    int unsigned chars_sent  = 0;
    int unsigned idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        text_bus.valid       = 1'b0;
        text_bus.char_in     = 8'h00;
        text_bus.end_of_text = 1'b0;
        word_bus.ready       = 1'b0;
    end

    function automatic void push_item(logic [7:0] c, logic eot);
        text_item_t t;
        t.ch  = c;
        t.eot = eot;
        stim_q.push_back(t);
    endfunction

    function automatic void put_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            lbuf.push_back(s.getc(i));
    endfunction

    function automatic void flush_line();
        int i;
        for (i = 0; i < lbuf.size(); i++)
            push_item(lbuf[i], 1'b0);
        lbuf.delete();
    endfunction

    // The final character of a text carries the end mark.
    function automatic void close_text();
        text_item_t t;
        if (stim_q.size() == 0)
            push_item(CH_LF, 1'b0);
        t = stim_q.pop_back();
        t.eot = 1'b1;
        stim_q.push_back(t);
    endfunction

    function automatic void put_operand(bit imm_field);
        int unsigned v;
        int          r;
        int          form;
        r = $urandom_range(0, 99);
        if (imm_field)
        begin
            if (r < 8)
                v = 0;
            else if (r < 16)
                v = mal_pkg::IMM_MAX;
            else if (r < 20)
                v = mal_pkg::NUM_SAT + $urandom_range(0, 10);
            else if (r < 23)
                v = $urandom_range(100000, 2000000000);
            else
                v = $urandom_range(0, 65535);
        end
        else
        begin
            if (r < 10)
                v = 0;
            else if (r < 20)
                v = mal_pkg::REG_MAX;
            else if (r < 90)
                v = $urandom_range(0, 31);
            else if (r < 96)
                v = $urandom_range(32, 99);
            else
                v = $urandom_range(100, 9999999);
        end
        form = $urandom_range(0, 99);
        if (form < 3)
            put_str("-");
        else if (form < 6)
            put_str("0");
        // A couple of percent carry no digits at all.
        if (form < 6 || form >= 8)
            put_str($sformatf("%0d", v));
        if (form >= 8 && form < 11)
        begin
            lbuf.push_back(8'($urandom_range("a", "z")));
            put_str($sformatf("%0d", $urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_line(bit broken);
        mnem_t id;
        bit    known;
        string nm;
        int    r;
        int    i;
        int    pos;
        lbuf.delete();
        r = $urandom_range(0, 99);
        known = (r >= 8);
        id = mnem_t'($urandom_range(0, 15));
        if (known)
        begin
            nm = board.spelled(id);
            r = $urandom_range(0, 9);
            if (r >= 4 && r <= 6)
                nm.putc(0, nm.getc(0) - 8'd32);
            else if (r >= 7 && r <= 8)
                nm = nm.toupper();
            else if (r == 9)
                nm.putc(nm.len() - 1, nm.getc(nm.len() - 1) - 8'd32);
        end
        else
        begin
            nm = "";
            r = $urandom_range(1, 6);
            for (i = 0; i < r; i++)
            begin
                if ($urandom_range(0, 1))
                    nm = {nm, string'(byte'($urandom_range("a", "z")))};
                else
                    nm = {nm, string'(byte'($urandom_range("A", "Z")))};
            end
        end
        put_str(nm);
        put_str(" $");
        put_operand(1'b0);
        put_str(", ");
        if (!known || id != MN_BGTZ)
        begin
            put_str("$");
            put_operand(1'b0);
            put_str(", ");
        end
        if (known && board.form_of(id) == FMT_R)
        begin
            put_str("$");
            put_operand(1'b0);
        end
        else if (known)
        begin
            put_str("#");
            put_operand(1'b1);
        end
        else
        begin
            put_str($urandom_range(0, 1) ? "$" : "#");
            put_operand(1'($urandom_range(0, 1)));
        end
        if (broken)
        begin
            pos = $urandom_range(0, lbuf.size() - 1);
            if ($urandom_range(0, 1))
                lbuf[pos] = 8'($urandom_range(0, 255));
            else
                while (lbuf.size() > pos)
                    void'(lbuf.pop_back());
        end
    endfunction

    function automatic void put_noise();
        int n;
        int i;
        lbuf.delete();
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            lbuf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_text(int nlines);
        int k;
        for (k = 0; k < nlines; k++)
        begin
            if ($urandom_range(0, 99) < 5)
                push_item(CH_LF, 1'b0);
            if ($urandom_range(0, 99) < 4)
                put_noise();
            else
                put_line($urandom_range(0, 99) < 15);
            flush_line();
            if (k < nlines - 1 || $urandom_range(0, 1))
                push_item(CH_LF, 1'b0);
        end
        close_text();
    endfunction

    // Enough one-letter lines to drive the line counter into saturation.
    function automatic void put_counter_text();
        int k;
        for (k = 0; k < 266; k++)
        begin
            if (k < 4 || k > 262)
                put_line(1'b0);
            else
            begin
                lbuf.delete();
                lbuf.push_back(8'($urandom_range("a", "z")));
            end
            flush_line();
            push_item(CH_LF, 1'b0);
        end
        close_text();
    endfunction

    function automatic void build_stimulus();
        bit long_done;
        long_done = 0;
        push_item(CH_LF, 1'b0);
        put_str("ADD $0, $31, $0");
        flush_line();
        push_item(CH_LF, 1'b0);
        put_str("Bgtz $31, #65535");
        flush_line();
        close_text();
        push_item(CH_LF, 1'b1);
        while (stim_q.size() < TEXT_TARGET)
        begin
            if (!long_done && stim_q.size() > 400)
            begin
                put_counter_text();
                long_done = 1;
            end
            else
                put_text($urandom_range(1, 10));
        end
    endfunction

    task automatic send_chars();
        while (chars_sent < stim_q.size())
        begin
            @(negedge clk);
            if ((chars_sent < 900 || chars_sent >= 1200) && $urandom_range(0, 99) < 20)
                text_bus.valid <= 1'b0;
            else
            begin
                text_bus.valid       <= 1'b1;
                text_bus.char_in     <= stim_q[chars_sent].ch;
                text_bus.end_of_text <= stim_q[chars_sent].eot;
                @(posedge clk);
                while (!text_bus.ready)
                    @(posedge clk);
                chars_sent++;
            end
        end
        @(negedge clk);
        text_bus.valid <= 1'b0;
    endtask

    task automatic pace_words();
        bit held;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (!held && words_seen >= 30)
            begin
                // Long hold-off: the record queue fills and the text side stalls.
                held = 1;
                word_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (words_seen >= 150 && words_seen < 230)
                word_bus.ready <= 1'b1;
            else
                word_bus.ready <= ($urandom_range(0, 99) >= 20);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_bus.valid && word_bus.ready) || (text_bus.valid && text_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (word_bus.valid && word_bus.ready)
            begin
                words_seen = words_seen + 1;
                board.compare_word({word_bus.instruction_word, word_bus.line_valid,
                                    word_bus.error_kind, word_bus.line_number,
                                    word_bus.error_seen, word_bus.first_error_line});
            end
            if (text_bus.valid && text_bus.ready)
                board.take_char(text_bus.char_in, text_bus.end_of_text);
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        pace_words();
    end

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_chars();
        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> files.f
sv/mal_pkg.sv
sv/mal_text_if.sv
sv/mal_word_if.sv
sv/mal_front.sv
sv/mal_queue.sv
sv/mal_back.sv
sv/mips_assembly_line_encoder_unit.sv
tb/sv/tb_top.sv
